@@ design/adp_alu_pkg.sv @@
// Shared types and constants for the ARM data-processing ALU core.
`timescale 1ns / 1ps

package adp_alu_pkg;

    // Sign bit of a 32-bit word
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    // Highest opcode of the compare/test group (TST..CMN)
    localparam logic [3:0] LAST_TEST_OP = 4'hB;
    // Register index of the program counter
    localparam logic [3:0] PC_INDEX = 4'hF;

    // Data-processing opcodes
    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } alu_op_t;

    // Barrel shifter types
    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_type_t;

    // One instruction transfer in
    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] rn_value;
        logic [31:0] rm_value;
        logic [31:0] rs_value;
        logic [3:0]  flags_in;
    } adp_alu_req_t;

    // One result transfer out
    typedef struct packed {
        logic        accepted;
        logic [31:0] result;
        logic [3:0]  dest_index;
        logic        dest_write;
        logic [3:0]  flags_out;
        logic        flags_write;
        logic        restore_status;
        logic        pc_load;
    } adp_alu_rsp_t;

    // Second operand with shifter carry-out
    typedef struct packed {
        logic [31:0] value;
        logic        carry;
    } adp_alu_opnd_t;

endpackage

@@ design/adp_alu_shifter.sv @@
// Second-operand generation: rotated immediate or shifted register with carry-out.
`timescale 1ns / 1ps

module adp_alu_shifter
    import adp_alu_pkg::*;
(
    input  logic [31:0]   instr,
    input  logic [31:0]   rm_value,
    input  logic [31:0]   rs_value,
    input  logic          carry_in,
    output adp_alu_opnd_t opnd
);

    logic        is_imm;
    logic        by_reg;
    shift_type_t sh_type;
    logic [4:0]  imm_amt;
    logic [7:0]  amt;
    logic [31:0] rm_eff;
    logic [31:0] imm_rot;
    logic [32:0] lsl_ext;
    logic [32:0] lsr_ext;
    logic [32:0] asr_ext;
    logic [31:0] ror_val;
    logic [5:0]  amt_clamp;

    assign is_imm  = instr[25];
    assign by_reg  = ~instr[25] & instr[4];
    assign sh_type = shift_type_t'(instr[6:5]);
    assign imm_amt = instr[11:7];

    // PC read as Rm is one word further ahead when the shift comes from Rs
    assign rm_eff = (by_reg && instr[3:0] == PC_INDEX) ? rm_value + 32'd4 : rm_value;

    // Shift amount; immediate LSR/ASR #0 means 32
    always_comb
    begin
        if (by_reg)
        begin
            amt = rs_value[7:0];
        end
        else if (imm_amt == 5'd0 && (sh_type == SHIFT_LSR || sh_type == SHIFT_ASR))
        begin
            amt = 8'd32;
        end
        else
        begin
            amt = {3'd0, imm_amt};
        end
    end

    // Amounts past 32 behave as 32 for ASR; other types handle them below
    assign amt_clamp = (amt > 8'd32) ? 6'd32 : amt[5:0];

    // Shift candidates, each with its carry-out bit alongside
    assign lsl_ext = {1'b0, rm_eff} << amt_clamp;
    assign lsr_ext = {rm_eff, 1'b0} >> amt_clamp;
    assign asr_ext = 33'($signed({rm_eff, 1'b0}) >>> amt_clamp);
    assign ror_val = (rm_eff >> amt[4:0]) | (rm_eff << (6'd32 - {1'b0, amt[4:0]}));

    // Rotated 8-bit immediate
    assign imm_rot = ({24'd0, instr[7:0]} >> {instr[11:8], 1'b0})
                   | ({24'd0, instr[7:0]} << (6'd32 - {1'b0, instr[11:8], 1'b0}));

    // Operand select
    always_comb
    begin
        opnd.value = rm_eff;
        opnd.carry = carry_in;
        if (is_imm)
        begin
            opnd.value = (instr[11:8] == 4'd0) ? {24'd0, instr[7:0]} : imm_rot;
            opnd.carry = (instr[11:8] == 4'd0) ? carry_in : opnd.value[31];
        end
        else if (!by_reg && imm_amt == 5'd0 && sh_type == SHIFT_ROR)
        begin
            // RRX
            opnd.value = {carry_in, rm_eff[31:1]};
            opnd.carry = rm_eff[0];
        end
        else if (amt != 8'd0)
        begin
            case (sh_type)
                SHIFT_LSL:
                begin
                    opnd.value = (amt > 8'd32) ? 32'd0 : lsl_ext[31:0];
                    opnd.carry = (amt > 8'd32) ? 1'b0 : lsl_ext[32];
                end
                SHIFT_LSR:
                begin
                    opnd.value = (amt > 8'd32) ? 32'd0 : lsr_ext[32:1];
                    opnd.carry = (amt > 8'd32) ? 1'b0 : lsr_ext[0];
                end
                SHIFT_ASR:
                begin
                    opnd.value = asr_ext[32:1];
                    opnd.carry = asr_ext[0];
                end
                default:
                begin
                    opnd.value = (amt[4:0] == 5'd0) ? rm_eff : ror_val;
                    opnd.carry = opnd.value[31];
                end
            endcase
        end
    end

endmodule

@@ design/arm_data_processing_alu_core.sv @@
// Top level: registered ARMv4 data-processing ALU with barrel shifter.
//
// Usage:
//   Input channel: drive req with the instruction word, the Rn, Rm and Rs
//   read values and the current NZCV flags, and pulse start. A transfer
//   takes place at each rising edge with start high and busy low; busy
//   stays low, so a new instruction can be given on every cycle.
//   Output channel: done is high for exactly one cycle with the result on
//   rsp. The receiver must take it in that cycle; it cannot stall.
//   The result is on rsp, with done high, once the instruction has
//   passed the input register and then one pass through shifter and
//   adder into the result register. Throughput: one instruction per
//   clock; busy is tied low, so nothing stalls a transfer.
//   An invalid encoding returns a result with every field zero.
//   Reset (rst_n low) clears the valid pipeline bits; nothing in flight
//   survives it and done stays low until new work arrives.
`timescale 1ns / 1ps

module arm_data_processing_alu_core
    import adp_alu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  adp_alu_req_t req,
    output logic         done,
    output adp_alu_rsp_t rsp
);

    logic          valid_reg;
    adp_alu_req_t  req_reg;
    logic          done_reg;
    adp_alu_rsp_t  rsp_reg;
    adp_alu_rsp_t  rsp_next;

    logic [31:0]   instr;
    alu_op_t       op;
    logic          s_bit;
    logic          by_reg;
    logic          carry_in;
    logic          is_test;
    logic          enc_valid;
    logic [31:0]   rn_eff;
    adp_alu_opnd_t opnd;
    logic [31:0]   add_a;
    logic [31:0]   add_b;
    logic          add_cin;
    logic [32:0]   add_sum;
    logic          is_arith;
    logic [31:0]   alu_res;
    logic          flag_n;
    logic          flag_z;
    logic          flag_c;
    logic          flag_v;
    logic          pcw;

    // Never stalls the issuer
    assign busy = 1'b0;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    // Decode
    assign instr    = req_reg.instr;
    assign op       = alu_op_t'(instr[24:21]);
    assign s_bit    = instr[20];
    assign by_reg   = ~instr[25] & instr[4];
    assign carry_in = req_reg.flags_in[1];
    assign is_test  = (instr[24:21] >= OP_TST) && (instr[24:21] <= LAST_TEST_OP);
    assign enc_valid = (instr[27:26] == 2'b00) && !(is_test && !s_bit)
                     && !(by_reg && instr[7]);

    // PC read as Rn is one word further ahead for register-shifted forms
    assign rn_eff = (by_reg && instr[19:16] == PC_INDEX)
                  ? req_reg.rn_value + 32'd4 : req_reg.rn_value;

    adp_alu_shifter u_shifter (
        .instr    (instr),
        .rm_value (req_reg.rm_value),
        .rs_value (req_reg.rs_value),
        .carry_in (carry_in),
        .opnd     (opnd)
    );

    // Adder operand select; subtraction as addition of the inverse
    always_comb
    begin
        add_a    = rn_eff;
        add_b    = opnd.value;
        add_cin  = 1'b0;
        is_arith = 1'b1;
        case (op)
            OP_SUB, OP_CMP:
            begin
                add_b   = ~opnd.value;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_a   = opnd.value;
                add_b   = ~rn_eff;
                add_cin = 1'b1;
            end
            OP_ADD, OP_CMN: add_cin = 1'b0;
            OP_ADC:         add_cin = carry_in;
            OP_SBC:
            begin
                add_b   = ~opnd.value;
                add_cin = carry_in;
            end
            OP_RSC:
            begin
                add_a   = opnd.value;
                add_b   = ~rn_eff;
                add_cin = carry_in;
            end
            default: is_arith = 1'b0;
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};

    // Result select
    always_comb
    begin
        case (op)
            OP_AND, OP_TST: alu_res = rn_eff & opnd.value;
            OP_EOR, OP_TEQ: alu_res = rn_eff ^ opnd.value;
            OP_ORR:         alu_res = rn_eff | opnd.value;
            OP_MOV:         alu_res = opnd.value;
            OP_BIC:         alu_res = rn_eff & ~opnd.value;
            OP_MVN:         alu_res = ~opnd.value;
            default:        alu_res = add_sum[31:0];
        endcase
    end

    // Flags: logical ops take the shifter carry and keep V
    assign flag_n = alu_res[31];
    assign flag_z = (alu_res == 32'd0);
    assign flag_c = is_arith ? add_sum[32] : opnd.carry;
    assign flag_v = is_arith ? ((add_a[31] == add_b[31]) && (alu_res[31] != add_a[31]))
                             : req_reg.flags_in[0];

    assign pcw = !is_test && (instr[15:12] == PC_INDEX);

    // Result assembly
    always_comb
    begin
        rsp_next = '0;
        if (enc_valid)
        begin
            rsp_next.accepted       = 1'b1;
            rsp_next.result         = pcw ? {alu_res[31:2], 2'b00} : alu_res;
            rsp_next.dest_index     = instr[15:12];
            rsp_next.dest_write     = !is_test;
            rsp_next.pc_load        = pcw;
            rsp_next.restore_status = s_bit && pcw;
            rsp_next.flags_write    = s_bit && !pcw;
            rsp_next.flags_out      = (s_bit && !pcw) ? {flag_n, flag_z, flag_c, flag_v}
                                                      : req_reg.flags_in;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Each accepted instruction yields a result with done high
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("accepted transfer produced no result");

    // A PC write is always word aligned
    a_pc_align: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.pc_load |-> rsp.result[1:0] == 2'b00)
        else $error("PC result not word aligned");

    // Status restore leaves the flags as they came in
    a_restore: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.restore_status |->
            !rsp.flags_write && rsp.flags_out == $past(req_reg.flags_in))
        else $error("flags changed during status restore");

    // Rejected encodings return an all-zero result
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.accepted |-> rsp == '0)
        else $error("rejected encoding with nonzero result");

endmodule

@@ dv/adp_alu_checker.sv @@
// Result checker for the ARM data-processing ALU core: predicts every transfer and compares.
`timescale 1ns / 1ps

module adp_alu_checker
    import adp_alu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  adp_alu_req_t req,
    input  logic         done,
    input  adp_alu_rsp_t rsp,
    output int           mismatches,
    output int           pending,
    output int           compared
);

    // Predicted results, oldest first
    adp_alu_rsp_t expected_results[$];
    int           err_count = 0;
    int           cmp_count = 0;

    // Rotate right by 0..31
    function automatic logic [31:0] rotr32(logic [31:0] v, logic [4:0] a);
        logic [63:0] d;
        d = {v, v} >> a;
        return d[31:0];
    endfunction

    // Barrel shifter, amount 0..255; amount 0 keeps value and carry
    function automatic adp_alu_opnd_t barrel_shift(logic [31:0] v, shift_type_t kind,
                                                   logic [7:0] amt, logic cin);
        adp_alu_opnd_t o;
        logic [4:0]    rot;
        o.value = v;
        o.carry = cin;
        rot     = amt[4:0];
        if (amt != 8'd0)
        begin
            case (kind)
                SHIFT_LSL:
                begin
                    if (amt < 8'd32)
                    begin
                        o.carry = v[32 - amt];
                        o.value = v << amt;
                    end
                    else
                    begin
                        o.carry = (amt == 8'd32) ? v[0] : 1'b0;
                        o.value = '0;
                    end
                end
                SHIFT_LSR:
                begin
                    if (amt < 8'd32)
                    begin
                        o.carry = v[amt - 1];
                        o.value = v >> amt;
                    end
                    else
                    begin
                        o.carry = (amt == 8'd32) ? v[31] : 1'b0;
                        o.value = '0;
                    end
                end
                SHIFT_ASR:
                begin
                    if (amt < 8'd32)
                    begin
                        o.carry = v[amt - 1];
                        o.value = $signed(v) >>> amt;
                    end
                    else
                    begin
                        o.carry = v[31];
                        o.value = {32{v[31]}};
                    end
                end
                default:
                begin
                    if (rot == 5'd0)
                        o.carry = v[31];
                    else
                    begin
                        o.carry = v[rot - 1];
                        o.value = rotr32(v, rot);
                    end
                end
            endcase
        end
        return o;
    endfunction

    // Expected result of one data-processing instruction
    function automatic adp_alu_rsp_t predict_dp_result(adp_alu_req_t q);
        adp_alu_rsp_t  p;
        adp_alu_opnd_t sh;
        logic [31:0]   ins, rn, rm, opnd, r;
        logic [32:0]   wide;
        logic [4:0]    amt5;
        logic [7:0]    amt8;
        logic [3:0]    rni, rdi, opc;
        shift_type_t   kind;
        alu_op_t       op;
        logic          s, is_imm, by_reg, cin, c, v, n, z;
        logic          borrow, test, wr, pcw, restore, fw, valid;

        ins    = q.instr;
        rn     = q.rn_value;
        rm     = q.rm_value;
        is_imm = ins[25];
        opc    = ins[24:21];
        op     = alu_op_t'(opc);
        s      = ins[20];
        rni    = ins[19:16];
        rdi    = ins[15:12];
        by_reg = !is_imm && ins[4];
        kind   = shift_type_t'(ins[6:5]);
        cin    = q.flags_in[1];
        c      = cin;
        v      = q.flags_in[0];
        borrow = !cin;
        test   = (opc >= OP_TST) && (opc <= LAST_TEST_OP);
        p      = '0;

        // Encoding checks
        valid = (ins[27:26] == 2'b00);
        if (test && !s)
            valid = 1'b0;
        if (by_reg && ins[7])
            valid = 1'b0;
        if (!valid)
            return p;

        // Second operand
        if (is_imm)
        begin
            amt5 = {ins[11:8], 1'b0};
            opnd = rotr32({24'd0, ins[7:0]}, amt5);
            if (amt5 != 5'd0)
                c = opnd[31];
        end
        else if (by_reg)
        begin
            if (ins[3:0] == PC_INDEX)
                rm = rm + 32'd4;
            if (rni == PC_INDEX)
                rn = rn + 32'd4;
            sh   = barrel_shift(rm, kind, q.rs_value[7:0], cin);
            opnd = sh.value;
            c    = sh.carry;
        end
        else
        begin
            amt5 = ins[11:7];
            if (amt5 == 5'd0 && kind == SHIFT_ROR)
            begin
                // RRX
                opnd = {cin, rm[31:1]};
                c    = rm[0];
            end
            else
            begin
                amt8 = {3'd0, amt5};
                if (amt5 == 5'd0 && (kind == SHIFT_LSR || kind == SHIFT_ASR))
                    amt8 = 8'd32;
                sh   = barrel_shift(rm, kind, amt8, cin);
                opnd = sh.value;
                c    = sh.carry;
            end
        end

        // ALU
        case (op)
            OP_AND, OP_TST: r = rn & opnd;
            OP_EOR, OP_TEQ: r = rn ^ opnd;
            OP_SUB, OP_CMP:
            begin
                r = rn - opnd;
                c = (rn >= opnd);
                v = (((rn ^ opnd) & (rn ^ r) & SIGN_BIT) != 32'd0);
            end
            OP_RSB:
            begin
                r = opnd - rn;
                c = (opnd >= rn);
                v = (((rn ^ opnd) & (opnd ^ r) & SIGN_BIT) != 32'd0);
            end
            OP_ADD, OP_CMN, OP_ADC:
            begin
                wide = {1'b0, rn} + {1'b0, opnd} + {32'd0, (op == OP_ADC) ? cin : 1'b0};
                r    = wide[31:0];
                c    = wide[32];
                v    = ((~(rn ^ opnd) & (rn ^ r) & SIGN_BIT) != 32'd0);
            end
            OP_SBC:
            begin
                wide = {1'b0, rn} - {1'b0, opnd} - {32'd0, borrow};
                r    = wide[31:0];
                c    = ({1'b0, rn} >= ({1'b0, opnd} + {32'd0, borrow}));
                v    = (((rn ^ opnd) & (rn ^ r) & SIGN_BIT) != 32'd0);
            end
            OP_RSC:
            begin
                wide = {1'b0, opnd} - {1'b0, rn} - {32'd0, borrow};
                r    = wide[31:0];
                c    = ({1'b0, opnd} >= ({1'b0, rn} + {32'd0, borrow}));
                v    = (((rn ^ opnd) & (opnd ^ r) & SIGN_BIT) != 32'd0);
            end
            OP_ORR: r = rn | opnd;
            OP_MOV: r = opnd;
            OP_BIC: r = rn & ~opnd;
            default: r = ~opnd;
        endcase
        n = r[31];
        z = (r == 32'd0);

        // Write-back control
        wr      = !test;
        pcw     = wr && (rdi == PC_INDEX);
        restore = s && pcw;
        fw      = s && !restore;
        if (pcw)
            r[1:0] = 2'b00;

        p.accepted       = 1'b1;
        p.result         = r;
        p.dest_index     = rdi;
        p.dest_write     = wr;
        p.flags_out      = fw ? {n, z, c, v} : q.flags_in;
        p.flags_write    = fw;
        p.restore_status = restore;
        p.pc_load        = pcw;
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Watch both channels
    always @(posedge clk)
    begin
        adp_alu_rsp_t want;
        if (!rst_n)
            expected_results.delete();
        else
        begin
            if (start && !busy)
                expected_results.push_back(predict_dp_result(req));
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", rsp.result, 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    check_field("accepted", 32'(rsp.accepted), 32'(want.accepted));
                    check_field("result", rsp.result, want.result);
                    check_field("dest_index", 32'(rsp.dest_index), 32'(want.dest_index));
                    check_field("dest_write", 32'(rsp.dest_write), 32'(want.dest_write));
                    check_field("flags_out", 32'(rsp.flags_out), 32'(want.flags_out));
                    check_field("flags_write", 32'(rsp.flags_write),
                                32'(want.flags_write));
                    check_field("restore_status", 32'(rsp.restore_status),
                                32'(want.restore_status));
                    check_field("pc_load", 32'(rsp.pc_load), 32'(want.pc_load));
                    cmp_count++;
                end
            end
        end
        mismatches <= err_count;
        pending    <= expected_results.size();
        compared   <= cmp_count;
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for the ARM data-processing ALU core: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import adp_alu_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic         done;
    adp_alu_req_t req;
    adp_alu_rsp_t rsp;
    int           mismatches;
    int           pending;
    int           compared;
    int           burst_left = 0;
    int           sent = 0;

    arm_data_processing_alu_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    adp_alu_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Hang guard
    initial
    begin
        #1_000_000;
        $display("[arm_data_processing_alu_core] ERROR");
        $finish;
    end

    // Data-processing word with condition field 0000
    function automatic logic [31:0] dp_word(logic imm, alu_op_t op, logic s,
                                            logic [3:0] rn, logic [3:0] rd, logic [11:0] op2);
        return {4'h0, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    // Operand 2: Rm shifted by immediate
    function automatic logic [11:0] sh_imm(logic [4:0] amt, shift_type_t kind, logic [3:0] rm);
        return {amt, kind, 1'b0, rm};
    endfunction

    // Operand 2: Rm shifted by Rs
    function automatic logic [11:0] sh_reg(logic [3:0] rs, shift_type_t kind, logic [3:0] rm);
        return {rs, 1'b0, kind, 1'b1, rm};
    endfunction

    function automatic adp_alu_req_t make_req(logic [31:0] ins, logic [31:0] rn,
                                              logic [31:0] rm, logic [31:0] rs,
                                              logic [3:0] fl);
        adp_alu_req_t q;
        q.instr    = ins;
        q.rn_value = rn;
        q.rm_value = rm;
        q.rs_value = rs;
        q.flags_in = fl;
        return q;
    endfunction

    // Operand value with bias toward corner words
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return SIGN_BIT;
            3: return 32'h7FFF_FFFF;
            4: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Rs value with the shift amount byte spread over the interesting ranges
    function automatic logic [31:0] rand_rs();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w[7:0] = 8'd0;
            1: w[7:0] = 8'd32;
            2: w[7:0] = 8'd255;
            3: w[7:0] = 8'($urandom_range(33, 254));
            default: w[7:0] = 8'($urandom_range(1, 31));
        endcase
        return w;
    endfunction

    // Mostly well-formed instructions, some raw noise words
    function automatic adp_alu_req_t rand_req();
        logic [31:0] ins;
        logic [11:0] op2;
        logic [3:0]  rn, rd, rm, opc;
        logic        s, imm;
        shift_type_t kind;
        kind = shift_type_t'($urandom_range(0, 3));
        rm   = ($urandom_range(0, 5) == 0) ? PC_INDEX : 4'($urandom);
        rn   = ($urandom_range(0, 5) == 0) ? PC_INDEX : 4'($urandom);
        rd   = ($urandom_range(0, 4) == 0) ? PC_INDEX : 4'($urandom);
        opc  = 4'($urandom);
        imm  = $urandom_range(0, 2) == 0;
        if (opc >= OP_TST && opc <= LAST_TEST_OP)
            s = $urandom_range(0, 7) != 0;
        else
            s = 1'($urandom_range(0, 1));
        if (imm)
            op2 = 12'($urandom);
        else if ($urandom_range(0, 1) == 0)
        begin
            op2 = sh_reg(4'($urandom), kind, rm);
            if ($urandom_range(0, 11) == 0)
                op2[7] = 1'b1;
        end
        else
            op2 = sh_imm(($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom), kind, rm);
        ins = dp_word(imm, alu_op_t'(opc), s, rn, rd, op2);
        ins[31:28] = 4'($urandom);
        if ($urandom_range(0, 9) == 0)
            ins = $urandom;
        return make_req(ins, rand_word(), rand_word(), rand_rs(), 4'($urandom));
    endfunction

    // One instruction transfer, paced in bursts with random gaps
    task automatic drive_item(input adp_alu_req_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        start = 1'b1;
        req   = item;
        do @(posedge clk); while (busy);
        burst_left--;
        sent++;
    endtask

    // Hold off until every predicted result has been seen
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial
    begin
        adp_alu_req_t dir_q[$];
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: every opcode, shifter corners, invalid words, PC writes
        dir_q.push_back(make_req(dp_word(1'b1, OP_AND, 1'b1, 4'd1, 4'd2, 12'h0FF),
                                 32'hFFFF_FFFF, 0, 0, 4'h0));
        dir_q.push_back(make_req(dp_word(1'b1, OP_EOR, 1'b1, 4'd1, 4'd2, 12'h2FF),
                                 32'h0000_0000, 0, 0, 4'h2));
        // Immediate LSL #0 keeps carry
        dir_q.push_back(make_req(dp_word(1'b0, OP_SUB, 1'b1, 4'd1, 4'd2,
                                         sh_imm(5'd0, SHIFT_LSL, 4'd3)),
                                 32'h0, 32'hFFFF_FFFF, 0, 4'h2));
        // LSR #0 means LSR #32
        dir_q.push_back(make_req(dp_word(1'b0, OP_RSB, 1'b1, 4'd1, 4'd2,
                                         sh_imm(5'd0, SHIFT_LSR, 4'd3)),
                                 32'h1, SIGN_BIT, 0, 4'h0));
        // ASR #0 means ASR #32; signed overflow on add
        dir_q.push_back(make_req(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd2,
                                         sh_imm(5'd0, SHIFT_ASR, 4'd3)),
                                 SIGN_BIT, SIGN_BIT, 0, 4'h0));
        // ROR #0 is RRX
        dir_q.push_back(make_req(dp_word(1'b0, OP_ADC, 1'b1, 4'd1, 4'd2,
                                         sh_imm(5'd0, SHIFT_ROR, 4'd3)),
                                 32'h7FFF_FFFF, 32'h0000_0001, 0, 4'h2));
        dir_q.push_back(make_req(dp_word(1'b0, OP_SBC, 1'b1, 4'd1, 4'd2,
                                         sh_imm(5'd31, SHIFT_LSL, 4'd3)),
                                 32'h0, 32'hFFFF_FFFF, 0, 4'h0));
        dir_q.push_back(make_req(dp_word(1'b0, OP_RSC, 1'b1, 4'd1, 4'd2,
                                         sh_reg(4'd4, SHIFT_LSR, 4'd3)),
                                 32'hFFFF_FFFF, SIGN_BIT, 32'hFFFF_FF20, 4'h2));
        // Test opcode with Rd of PC only writes flags
        dir_q.push_back(make_req(dp_word(1'b0, OP_TST, 1'b1, 4'd1, PC_INDEX,
                                         sh_reg(4'd4, SHIFT_ASR, 4'd3)),
                                 32'hFFFF_FFFF, SIGN_BIT, 32'h0000_00FF, 4'hF));
        dir_q.push_back(make_req(dp_word(1'b0, OP_TEQ, 1'b1, 4'd1, 4'd2,
                                         sh_reg(4'd4, SHIFT_ROR, 4'd3)),
                                 32'h1234_5678, SIGN_BIT, 32'h0000_0020, 4'h0));
        dir_q.push_back(make_req(dp_word(1'b1, OP_CMP, 1'b1, 4'd1, 4'd2, 12'hF01),
                                 32'h0, 0, 0, 4'h0));
        dir_q.push_back(make_req(dp_word(1'b1, OP_CMN, 1'b1, 4'd1, 4'd2, 12'h001),
                                 32'hFFFF_FFFF, 0, 0, 4'h0));
        // Register shift by zero; Rn and Rm of PC read plus four
        dir_q.push_back(make_req(dp_word(1'b0, OP_ORR, 1'b1, PC_INDEX, 4'd2,
                                         sh_reg(4'd4, SHIFT_LSL, PC_INDEX)),
                                 32'hFFFF_FFFC, 32'h0000_0010, 32'hFFFF_FF00, 4'hA));
        // PC write without S: word aligned
        dir_q.push_back(make_req(dp_word(1'b0, OP_MOV, 1'b0, 4'd0, PC_INDEX,
                                         sh_imm(5'd0, SHIFT_LSL, 4'd3)),
                                 32'h0, 32'hFFFF_FFFF, 0, 4'h5));
        // PC write with S: status restore
        dir_q.push_back(make_req(dp_word(1'b0, OP_BIC, 1'b1, 4'd1, PC_INDEX,
                                         sh_imm(5'd1, SHIFT_LSL, 4'd3)),
                                 32'hFFFF_FFFF, 32'h0000_0001, 0, 4'h9));
        dir_q.push_back(make_req(dp_word(1'b0, OP_MVN, 1'b1, 4'd1, 4'd2,
                                         sh_reg(4'd4, SHIFT_LSL, 4'd3)),
                                 32'h0, 32'hFFFF_FFFF, 32'h0000_0021, 4'h0));
        dir_q.push_back(make_req(dp_word(1'b0, OP_MOV, 1'b1, 4'd1, 4'd2,
                                         sh_reg(4'd4, SHIFT_LSL, PC_INDEX)),
                                 32'h0, 32'hFFFF_FFFD, 32'h0000_0020, 4'h0));
        // Invalid: not a data-processing class
        dir_q.push_back(make_req(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd2, 12'h003)
                                 | 32'h0400_0000,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
        // Invalid: compare with S clear
        dir_q.push_back(make_req(dp_word(1'b0, OP_CMP, 1'b0, 4'd1, 4'd2, 12'h003),
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
        // Invalid: register shift with bit 7 set
        dir_q.push_back(make_req(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd2,
                                         sh_reg(4'd4, SHIFT_LSL, 4'd3) | 12'h080),
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
        // No S: flags pass through
        dir_q.push_back(make_req(dp_word(1'b0, OP_ADD, 1'b0, 4'd1, 4'd2,
                                         sh_imm(5'd0, SHIFT_LSL, 4'd3)),
                                 32'hFFFF_FFFF, 32'h1, 0, 4'hF));
        dir_q.push_back(make_req(dp_word(1'b0, OP_SUB, 1'b1, 4'd1, 4'd2,
                                         sh_imm(5'd0, SHIFT_LSL, 4'd3)),
                                 SIGN_BIT, 32'h1, 0, 4'h0));
        // Condition field must be ignored
        dir_q.push_back(make_req(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd2,
                                         sh_imm(5'd4, SHIFT_ROR, 4'd3))
                                 | 32'hF000_0000,
                                 32'h8765_4321, 32'hDEAD_BEEF, 0, 4'h6));
        foreach (dir_q[i])
            drive_item(dir_q[i]);
        wait_drained();

        // Random part
        for (int i = 0; i < 550; i++)
        begin
            if (i == 275)
                wait_drained();
            drive_item(rand_req());
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (pending != 0)
            $display("%0d predicted results never arrived", pending);
        $display("%0d instructions sent, %0d results compared field by field", sent, compared);
        $display("covered: all opcodes, immediate and shifted operands, invalid words, PC writes");
        if (mismatches == 0 && pending == 0)
            $display("[arm_data_processing_alu_core] OK");
        else
            $display("[arm_data_processing_alu_core] ERROR");
        $finish;
    end

endmodule
